@@ design/atre_pkg.sv @@
package atre_pkg;

  localparam int TotalBits = 24;
  localparam int PixW      = 8;
  localparam int RunW      = 7;
  localparam int MaxBytes  = 4;
  localparam int CntW      = $clog2(MaxBytes + 1);
  localparam int SlotW     = $clog2(MaxBytes);
  localparam int NumCand   = 5;

  localparam logic OpAnalyze = 1'b0;
  localparam logic OpEncode  = 1'b1;

  localparam logic [PixW-1:0] ThrClass0 = 8'hF0;
  localparam logic [PixW-1:0] ThrClass1 = 8'hE0;
  localparam logic [PixW-1:0] ThrClass2 = 8'hC0;
  localparam logic [PixW-1:0] ThrClass3 = 8'h80;
  localparam logic [PixW-1:0] ThrReset  = 8'h80;
  localparam logic [PixW-1:0] ByteMax   = 8'hFF;
  localparam logic [RunW-1:0] AnalyzeCap = 7'h7F;

  localparam logic [RunW-1:0] LenClass1 = 7'd16;
  localparam logic [RunW-1:0] LenClass2 = 7'd32;
  localparam logic [RunW-1:0] LenClass3 = 7'd64;
  localparam logic [RunW-1:0] LenMinRun = 7'd2;

  typedef logic [PixW-1:0]      pix_t;
  typedef logic [RunW-1:0]      run_len_t;
  typedef logic [TotalBits-1:0] total_t;

  typedef struct packed {
    logic [MaxBytes-1:0][PixW-1:0] bytes;
    logic [CntW-1:0]               cnt;
    logic                          last;
  } bundle_t;

  typedef struct packed {
    logic [1:0] n;
    pix_t       b0;
    pix_t       b1;
  } pair_t;

  function automatic pix_t thr_of_class(input logic [1:0] cls);
    pix_t t;
    unique case (cls)
      2'd0:    t = ThrClass0;
      2'd1:    t = ThrClass1;
      2'd2:    t = ThrClass2;
      default: t = ThrClass3;
    endcase
    return t;
  endfunction

  function automatic pair_t enc_close(input run_len_t len, input pix_t val, input pix_t thr);
    pair_t p;
    logic [PixW:0] code;
    code = {1'b0, thr} + {{(PixW + 1 - RunW){1'b0}}, len};
    if (len == run_len_t'(1)) begin
      if (val >= thr) begin
        p.n  = 2'd2;
        p.b0 = thr + pix_t'(1);
        p.b1 = val;
      end else begin
        p.n  = 2'd1;
        p.b0 = val;
        p.b1 = val;
      end
    end else begin
      p.n  = 2'd2;
      p.b0 = code[PixW] ? ByteMax : code[PixW-1:0];
      p.b1 = val;
    end
    return p;
  endfunction

endpackage

@@ design/atre_pix_if.sv @@
interface atre_pix_if;
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [atre_pkg::PixW-1:0] pixel;
  logic                     frame_end;

  modport source (output valid, operation, pixel, frame_end, input ready);
  modport sink   (input valid, operation, pixel, frame_end, output ready);
endinterface

@@ design/atre_code_if.sv @@
interface atre_code_if;
  logic                     valid;
  logic                     ready;
  logic [atre_pkg::PixW-1:0] code_byte;
  logic                     stream_end;

  modport source (output valid, code_byte, stream_end, input ready);
  modport sink   (input valid, code_byte, stream_end, output ready);
endinterface

@@ design/atre_emit.sv @@
module atre_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  atre_pkg::bundle_t bundle_i,
  output logic              free_o,
  atre_code_if.source       out_o
);

  logic [atre_pkg::MaxBytes-1:0][atre_pkg::PixW-1:0] bytes_q;
  logic [atre_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [atre_pkg::CntW-1:0] rd_q, rd_d;
  logic                      last_q;
  logic                      pop;

  assign out_o.valid      = rd_q != cnt_q;
  assign out_o.code_byte  = bytes_q[rd_q[atre_pkg::SlotW-1:0]];
  assign out_o.stream_end = last_q && (rd_q + atre_pkg::CntW'(1) == cnt_q);
  assign pop              = out_o.valid && out_o.ready;
  assign free_o           = !out_o.valid || (pop && (rd_q + atre_pkg::CntW'(1) == cnt_q));

  always_comb begin
    cnt_d = cnt_q;
    rd_d  = rd_q;
    if (load_i) begin
      cnt_d = bundle_i.cnt;
      rd_d  = '0;
    end else if (pop) begin
      rd_d = rd_q + atre_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= bundle_i.bytes;
      last_q  <= bundle_i.last;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= atre_pkg::CntW'(atre_pkg::MaxBytes) && rd_q <= cnt_q)
    else $error("emit read pointer past byte count");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("bundle loaded over undelivered bytes");

  a_pop_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !load_i |=> rd_q == $past(rd_q) + atre_pkg::CntW'(1))
    else $error("read pointer did not advance on beat");

endmodule

@@ design/adaptive_threshold_rle_encoder.sv @@
// Adaptive-threshold run-length encoder for 8-bit pixels.
// in_i carries pixel beats (operation, pixel, frame_end); out_o carries the
// coded byte stream (code_byte, stream_end). Both use valid/ready.
// A frame is sent twice: first with operation 0 (analyze), which emits
// nothing and sets the threshold from the run-length class totals, then with
// operation 1 (encode), which emits the threshold header and the run codes.
// Each accepted beat is turned into a bundle of up to four bytes held in the
// output buffer; the first byte is visible the cycle after acceptance. The
// buffer drains one byte per cycle while out_o.ready is high, so a beat is
// taken when no threshold pick is pending and the buffer is empty or its last
// byte leaves in the same cycle. Beats that yield at most one byte (analyze
// beats and run extensions that do not end the frame included) are taken
// back to back while out_o is ready; otherwise the next beat waits until
// the bundle has drained, e.g. after a pixel that yields an escape or run
// code plus the pixel. After the last pixel of an analyze pass input is
// held off while the threshold is chosen. A stall on out_o holds the
// buffer and keeps in_i.ready low until its last byte leaves.
// Reset clears the totals and run state, sets the threshold to 0x80 and
// empties the output buffer.
module adaptive_threshold_rle_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  atre_pix_if.sink    in_i,
  atre_code_if.source out_o
);

  atre_pkg::total_t [3:0] totals_q, totals_d;
  atre_pkg::pix_t         run_val_q, run_val_d;
  atre_pkg::run_len_t     run_len_q, run_len_d;
  atre_pkg::pix_t         thr_q, thr_d;
  logic                   in_pass_q, in_pass_d;
  logic                   pick_q, pick_d;

  logic                   free;
  logic                   accept;
  logic                   start, is_enc, extend;
  atre_pkg::run_len_t     rl_eff, new_len, add_len;
  logic [atre_pkg::PixW-1:0] cap;
  atre_pkg::pix_t         new_val;
  logic [1:0]             add_cls;
  logic                   add_en;
  atre_pkg::total_t       add_base;
  logic [atre_pkg::TotalBits:0] add_sum;
  atre_pkg::pair_t        c1, c2;
  atre_pkg::pix_t [atre_pkg::NumCand-1:0] cand_b;
  logic [atre_pkg::NumCand-1:0]           cand_v;
  atre_pkg::bundle_t      bundle;
  logic [1:0]             best;
  atre_pkg::total_t       best_v;

  assign in_i.ready = free && !pick_q;
  assign accept     = in_i.valid && in_i.ready;

  assign start   = !in_pass_q;
  assign is_enc  = in_i.operation == atre_pkg::OpEncode;
  assign rl_eff  = start ? '0 : run_len_q;
  assign cap     = is_enc ? (atre_pkg::ByteMax - thr_q) : {1'b0, atre_pkg::AnalyzeCap};
  assign extend  = (rl_eff != '0) && (in_i.pixel == run_val_q) && ({1'b0, rl_eff} < cap);
  assign new_len = extend ? rl_eff + atre_pkg::run_len_t'(1) : atre_pkg::run_len_t'(1);
  assign new_val = extend ? run_val_q : in_i.pixel;

  // only one run can close with length two or more per beat
  assign add_len = extend ? (in_i.frame_end ? new_len : '0) : rl_eff;

  always_comb begin
    add_en  = !is_enc && (add_len >= atre_pkg::LenMinRun);
    priority if (add_len >= atre_pkg::LenClass3) add_cls = 2'd3;
    else if (add_len >= atre_pkg::LenClass2)     add_cls = 2'd2;
    else if (add_len >= atre_pkg::LenClass1)     add_cls = 2'd1;
    else                                         add_cls = 2'd0;
  end

  assign add_base = totals_q[add_cls];
  assign add_sum  = {1'b0, add_base}
                  + {{(atre_pkg::TotalBits + 1 - atre_pkg::RunW){1'b0}}, add_len};

  always_comb begin
    totals_d = totals_q;
    if (start && !is_enc) begin
      totals_d = '0;
    end else if (add_en) begin
      totals_d[add_cls] = add_sum[atre_pkg::TotalBits] ? '1
                                                       : add_sum[atre_pkg::TotalBits-1:0];
    end
  end

  assign c1 = atre_pkg::enc_close(rl_eff, run_val_q, thr_q);
  assign c2 = atre_pkg::enc_close(new_len, new_val, thr_q);

  always_comb begin
    cand_b[0] = thr_q;
    cand_v[0] = start && is_enc;
    cand_b[1] = c1.b0;
    cand_v[1] = is_enc && !extend && (rl_eff != '0);
    cand_b[2] = c1.b1;
    cand_v[2] = cand_v[1] && (c1.n == 2'd2);
    cand_b[3] = c2.b0;
    cand_v[3] = is_enc && in_i.frame_end;
    cand_b[4] = c2.b1;
    cand_v[4] = cand_v[3] && (c2.n == 2'd2);
  end

  always_comb begin
    bundle.bytes = '0;
    bundle.cnt   = '0;
    bundle.last  = is_enc && in_i.frame_end;
    for (int i = 0; i < atre_pkg::NumCand; i++) begin
      if (cand_v[i]) begin
        bundle.bytes[bundle.cnt[atre_pkg::SlotW-1:0]] = cand_b[i];
        bundle.cnt = bundle.cnt + atre_pkg::CntW'(1);
      end
    end
  end

  // ties go to the longer class
  always_comb begin
    best   = 2'd0;
    best_v = totals_q[0];
    for (int i = 1; i < 4; i++) begin
      if (totals_q[i] >= best_v) begin
        best   = 2'(i);
        best_v = totals_q[i];
      end
    end
  end

  always_comb begin
    run_val_d = run_val_q;
    run_len_d = run_len_q;
    in_pass_d = in_pass_q;
    pick_d    = 1'b0;
    thr_d     = pick_q ? atre_pkg::thr_of_class(best) : thr_q;
    if (accept) begin
      run_val_d = new_val;
      run_len_d = in_i.frame_end ? '0 : new_len;
      in_pass_d = !in_i.frame_end;
      pick_d    = in_i.frame_end && !is_enc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      totals_q  <= '0;
      run_val_q <= '0;
      run_len_q <= '0;
      thr_q     <= atre_pkg::ThrReset;
      in_pass_q <= 1'b0;
      pick_q    <= 1'b0;
    end else begin
      if (accept) begin
        totals_q <= totals_d;
      end
      run_val_q <= run_val_d;
      run_len_q <= run_len_d;
      thr_q     <= thr_d;
      in_pass_q <= in_pass_d;
      pick_q    <= pick_d;
    end
  end

  atre_emit u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .bundle_i (bundle),
    .free_o   (free),
    .out_o    (out_o)
  );

  a_pick_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pick_q |=> !pick_q)
    else $error("threshold pick held longer than one cycle");

  a_pick_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pick_q |-> !in_i.ready)
    else $error("beat taken during threshold pick");

  a_open_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_pass_q |-> run_len_q != '0)
    else $error("pass open without a run");

  a_thr_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    thr_q == atre_pkg::ThrClass0 || thr_q == atre_pkg::ThrClass1 ||
    thr_q == atre_pkg::ThrClass2 || thr_q == atre_pkg::ThrClass3)
    else $error("threshold outside class table");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 8;

  typedef struct packed {
    atre_pkg::pix_t code_byte;
    logic           stream_end;
  } code_beat_t;

  logic clk_i;
  logic rst_ni;

  atre_pix_if  pix_bus ();
  atre_code_if code_bus ();

  adaptive_threshold_rle_encoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pix_bus.sink),
    .out_o  (code_bus.source)
  );

  // encoder state as predicted from the accepted pixel beats
  atre_pkg::total_t class_sum [4] = '{default: '0};
  atre_pkg::pix_t   open_val      = '0;
  int               open_len      = 0;
  atre_pkg::pix_t   cur_thr       = atre_pkg::ThrReset;
  bit               pass_open     = 1'b0;
  int               step_bytes;
  code_beat_t       pending_codes [$];

  atre_pkg::pix_t thr_by_class [4] = '{atre_pkg::ThrClass0, atre_pkg::ThrClass1,
                                       atre_pkg::ThrClass2, atre_pkg::ThrClass3};

  int src_idle_pct  = 0;
  int snk_idle_pct  = 0;
  int pixel_beats   = 0;
  int code_beats    = 0;
  int frames_sent   = 0;
  int fail_count    = 0;
  int quiet_cycles  = 0;
  int thr_picks [4] = '{default: 0};
  code_beat_t want;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(negedge clk_i) begin
    code_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  task automatic emit_code(input atre_pkg::pix_t b);
    code_beat_t cb;
    cb.code_byte = b;
    cb.stream_end = 1'b0;
    pending_codes.push_back(cb);
    step_bytes++;
  endtask

  task automatic add_class_sum(input int cls, input int len);
    longint lim;
    longint s;
    lim = (longint'(1) << atre_pkg::TotalBits) - 1;
    s = longint'(class_sum[cls]) + len;
    if (s > lim) s = lim;
    class_sum[cls] = atre_pkg::total_t'(s);
  endtask

  task automatic close_model_run(input logic op);
    int code;
    if (open_len == 0) return;
    if (op == atre_pkg::OpAnalyze) begin
      if (open_len >= int'(atre_pkg::LenClass3)) add_class_sum(3, open_len);
      else if (open_len >= int'(atre_pkg::LenClass2)) add_class_sum(2, open_len);
      else if (open_len >= int'(atre_pkg::LenClass1)) add_class_sum(1, open_len);
      else if (open_len >= int'(atre_pkg::LenMinRun)) add_class_sum(0, open_len);
    end else if (open_len == 1) begin
      if (open_val >= cur_thr) begin
        emit_code(cur_thr + atre_pkg::pix_t'(1));
        emit_code(open_val);
      end else begin
        emit_code(open_val);
      end
    end else begin
      code = int'(cur_thr) + open_len;
      if (code > int'(atre_pkg::ByteMax)) code = int'(atre_pkg::ByteMax);
      emit_code(atre_pkg::pix_t'(code));
      emit_code(open_val);
    end
    open_len = 0;
  endtask

  task automatic predict_codes(input logic op, input atre_pkg::pix_t px, input logic fe);
    int cap;
    int best;
    step_bytes = 0;
    if (!pass_open) begin
      open_len = 0;
      if (op == atre_pkg::OpAnalyze) begin
        foreach (class_sum[i]) class_sum[i] = '0;
      end else begin
        emit_code(cur_thr);
      end
      pass_open = 1'b1;
    end
    cap = (op == atre_pkg::OpEncode) ? int'(atre_pkg::ByteMax) - int'(cur_thr)
                                     : int'(atre_pkg::AnalyzeCap);
    if (open_len > 0 && px == open_val && open_len < cap) begin
      open_len++;
    end else begin
      close_model_run(op);
      open_val = px;
      open_len = 1;
    end
    if (fe) begin
      close_model_run(op);
      pass_open = 1'b0;
      if (op == atre_pkg::OpAnalyze) begin
        best = 0;
        for (int i = 1; i < 4; i++) begin
          if (class_sum[i] >= class_sum[best]) best = i;
        end
        cur_thr = thr_by_class[best];
        thr_picks[best]++;
      end else if (step_bytes > 0) begin
        pending_codes[$].stream_end = 1'b1;
      end
    end
  endtask

  // hold the beat until taken, then predict; returns at a falling edge
  task automatic send_pixel(input logic op, input atre_pkg::pix_t px, input logic fe);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    pix_bus.valid     = 1'b1;
    pix_bus.operation = op;
    pix_bus.pixel     = px;
    pix_bus.frame_end = fe;
    @(posedge clk_i);
    while (!pix_bus.ready) @(posedge clk_i);
    predict_codes(op, px, fe);
    pixel_beats++;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && code_bus.valid && code_bus.ready) begin
      code_beats++;
      if (pending_codes.size() == 0) begin
        $error("unexpected code beat: code_byte %02h stream_end %0b",
               code_bus.code_byte, code_bus.stream_end);
        fail_count++;
      end else begin
        want = pending_codes.pop_front();
        if (code_bus.code_byte !== want.code_byte) begin
          $error("code_byte mismatch: expected %02h actual %02h",
                 want.code_byte, code_bus.code_byte);
          fail_count++;
        end
        if (code_bus.stream_end !== want.stream_end) begin
          $error("stream_end mismatch: expected %0b actual %0b",
                 want.stream_end, code_bus.stream_end);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((pix_bus.valid && pix_bus.ready) || (code_bus.valid && code_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("watchdog: no beat for %0d cycles, %0d codes outstanding",
                 quiet_cycles, pending_codes.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // single-pixel frames around the reset threshold: escape, at-threshold, literal
  task automatic test_single_pixel_frames();
    send_pixel(atre_pkg::OpAnalyze, 8'h00, 1'b1);
    send_pixel(atre_pkg::OpEncode, 8'hFF, 1'b1);
    send_pixel(atre_pkg::OpEncode, 8'h80, 1'b1);
    send_pixel(atre_pkg::OpEncode, 8'h7F, 1'b1);
    send_pixel(atre_pkg::OpEncode, 8'h00, 1'b1);
  endtask

  // analyze-opened run longer than the encode cap, closed by encode beats
  task automatic test_overlong_run();
    send_pixel(atre_pkg::OpAnalyze, 8'h11, 1'b0);
    send_pixel(atre_pkg::OpAnalyze, 8'h11, 1'b0);
    send_pixel(atre_pkg::OpAnalyze, 8'h00, 1'b1);
    for (int i = 0; i < 17; i++) send_pixel(atre_pkg::OpAnalyze, 8'h5A, 1'b0);
    send_pixel(atre_pkg::OpEncode, 8'h5A, 1'b0);
    send_pixel(atre_pkg::OpEncode, 8'hFF, 1'b1);
    send_pixel(atre_pkg::OpEncode, 8'hF0, 1'b1);
    send_pixel(atre_pkg::OpEncode, 8'hEF, 1'b1);
  endtask

  // analyze then encode the same frame; runs biased toward one length class
  task automatic test_frames(input int target);
    int             start;
    int             bias;
    int             runs;
    int             len;
    int             roll;
    atre_pkg::pix_t val;
    atre_pkg::pix_t frame [$];
    start = pixel_beats;
    while (pixel_beats - start < target) begin
      if (frames_sent < 4) begin
        bias = frames_sent;
      end else begin
        roll = $urandom_range(99);
        bias = (roll < 50) ? 0 : (roll < 80) ? 1 : 2;
      end
      frame.delete();
      runs = $urandom_range(2, 3);
      for (int r = 0; r < runs; r++) begin
        if (r == 0) begin
          case (bias)
            0:       len = $urandom_range(2, 15);
            1:       len = $urandom_range(16, 20);
            2:       len = $urandom_range(32, 36);
            default: len = $urandom_range(64, 66);
          endcase
        end else if ($urandom_range(99) < 35) begin
          len = 1;
        end else begin
          len = $urandom_range(2, 6);
        end
        val = $urandom_range(1) ? atre_pkg::pix_t'($urandom_range(255))
                                : atre_pkg::pix_t'($urandom_range(128, 255));
        if (frame.size() > 0 && val == frame[$]) val = ~val;
        for (int k = 0; k < len; k++) frame.push_back(val);
      end
      foreach (frame[i]) send_pixel(atre_pkg::OpAnalyze, frame[i], i == frame.size() - 1);
      foreach (frame[i]) send_pixel(atre_pkg::OpEncode, frame[i], i == frame.size() - 1);
      frames_sent++;
    end
  endtask

  // random operation per beat, short runs, stray frame ends
  task automatic test_mixed_noise(input int count);
    atre_pkg::pix_t px;
    px = atre_pkg::pix_t'($urandom_range(255));
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 40) px = atre_pkg::pix_t'($urandom_range(255));
      send_pixel(logic'($urandom_range(1)), px, (i == count - 1) || ($urandom_range(99) < 8));
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    pix_bus.valid     = 1'b0;
    pix_bus.operation = atre_pkg::OpAnalyze;
    pix_bus.pixel     = '0;
    pix_bus.frame_end = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    src_idle_pct = 27;
    snk_idle_pct = 60;
    test_single_pixel_frames();
    test_overlong_run();
    test_frames(1);
    test_frames(1);

    src_idle_pct = 60;
    snk_idle_pct = 27;
    test_frames(1);
    test_mixed_noise(16);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_frames(1);
    test_mixed_noise(8);

    pix_bus.valid = 1'b0;
    while (pending_codes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("run covered %0d pixel beats, %0d code beats, %0d two-pass frames",
             pixel_beats, code_beats, frames_sent);
    $display("thresholds picked: F0 x%0d, E0 x%0d, C0 x%0d, 80 x%0d",
             thr_picks[0], thr_picks[1], thr_picks[2], thr_picks[3]);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/atre_pkg.sv
design/atre_pix_if.sv
design/atre_code_if.sv
design/atre_emit.sv
design/adaptive_threshold_rle_encoder.sv
tb/tb_top.sv
